// ===== rtl/ibgg_pkg.sv =====
// ----------------------------------------------------------------------------
// ibgg_pkg
// Shared types and constants of the ignition/button gesture gate.
// ----------------------------------------------------------------------------
package ibgg_pkg;

  localparam int TimeWidth   = 32;
  localparam int CfgIdxWidth = 3;

  typedef logic [TimeWidth-1:0]   time_ms_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t RegDebounce   = 3'd0;
  localparam cfg_idx_t RegArmTimeout = 3'd1;
  localparam cfg_idx_t RegOffSettle  = 3'd2;
  localparam cfg_idx_t RegPressHold  = 3'd3;
  localparam cfg_idx_t RegOnHold     = 3'd4;

  // reset values
  localparam time_ms_t DebounceRst   = 32'd80;
  localparam time_ms_t ArmTimeoutRst = 32'd30000;
  localparam time_ms_t OffSettleRst  = 32'd200;
  localparam time_ms_t PressHoldRst  = 32'd500;
  localparam time_ms_t OnHoldRst     = 32'd2000;

  // input actions
  localparam logic ActProcess = 1'b0;
  localparam logic ActInit    = 1'b1;

  typedef struct packed {
    time_ms_t debounce_ms;
    time_ms_t arm_timeout_ms;
    time_ms_t off_settle_ms;
    time_ms_t press_hold_ms;
    time_ms_t on_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic     action;
    time_ms_t now_ms;
    logic     ignition_on;
    logic     enter_button;
  } sample_t;

endpackage

// ===== rtl/ibgg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ibgg_cfg_regs
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module ibgg_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  ibgg_pkg::cfg_idx_t  cfg_index,
  input  ibgg_pkg::time_ms_t  cfg_data,
  output ibgg_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= ibgg_pkg::DebounceRst;
      cfg.arm_timeout_ms <= ibgg_pkg::ArmTimeoutRst;
      cfg.off_settle_ms  <= ibgg_pkg::OffSettleRst;
      cfg.press_hold_ms  <= ibgg_pkg::PressHoldRst;
      cfg.on_hold_ms     <= ibgg_pkg::OnHoldRst;
    end else if (cfg_write) begin
      case (cfg_index)
        ibgg_pkg::RegDebounce:   cfg.debounce_ms    <= cfg_data;
        ibgg_pkg::RegArmTimeout: cfg.arm_timeout_ms <= cfg_data;
        ibgg_pkg::RegOffSettle:  cfg.off_settle_ms  <= cfg_data;
        ibgg_pkg::RegPressHold:  cfg.press_hold_ms  <= cfg_data;
        ibgg_pkg::RegOnHold:     cfg.on_hold_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ibgg_gesture.sv =====
// ----------------------------------------------------------------------------
// ibgg_gesture
// Gesture state and its single-pass next-state logic for one sample.
// ----------------------------------------------------------------------------
module ibgg_gesture (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ibgg_pkg::sample_t smp,
  input  ibgg_pkg::cfg_t    cfg,
  output logic              fire
);

  logic               raw_button,       raw_button_next;
  ibgg_pkg::time_ms_t raw_change_time,  raw_change_time_next;
  logic               debounced_button, debounced_button_next;
  ibgg_pkg::time_ms_t press_start_time, press_start_time_next;
  logic               armed_flag,       armed_flag_next;
  logic               on_pending_flag,  on_pending_flag_next;
  logic               qualified_flag,   qualified_flag_next;
  logic               expired_flag,     expired_flag_next;
  ibgg_pkg::time_ms_t armed_since_time, armed_since_time_next;
  logic               off_known_flag,   off_known_flag_next;
  ibgg_pkg::time_ms_t off_since_time,   off_since_time_next;
  ibgg_pkg::time_ms_t on_since_time,    on_since_time_next;

  always_comb begin
    ibgg_pkg::time_ms_t now;
    logic               btn;
    now = smp.now_ms;
    btn = smp.enter_button;

    raw_button_next       = raw_button;
    raw_change_time_next  = raw_change_time;
    debounced_button_next = debounced_button;
    press_start_time_next = press_start_time;
    armed_flag_next       = armed_flag;
    on_pending_flag_next  = on_pending_flag;
    qualified_flag_next   = qualified_flag;
    expired_flag_next     = expired_flag;
    armed_since_time_next = armed_since_time;
    off_known_flag_next   = off_known_flag;
    off_since_time_next   = off_since_time;
    on_since_time_next    = on_since_time;
    fire                  = 1'b0;

    if (smp.action == ibgg_pkg::ActInit) begin
      raw_button_next       = btn;
      raw_change_time_next  = now;
      debounced_button_next = 1'b0;
      press_start_time_next = now;
      armed_flag_next       = 1'b0;
      on_pending_flag_next  = 1'b0;
      qualified_flag_next   = 1'b0;
      expired_flag_next     = 1'b0;
      armed_since_time_next = '0;
      off_known_flag_next   = 1'b0;
      off_since_time_next   = '0;
      on_since_time_next    = '0;
    end else begin
      if (btn != raw_button) begin
        raw_button_next      = btn;
        raw_change_time_next = now;
      end
      // debounce: follow raw once it has been stable long enough
      if ((raw_button_next != debounced_button) &&
          ((now - raw_change_time_next) >= cfg.debounce_ms)) begin
        debounced_button_next = raw_button_next;
        if (raw_button_next) begin
          press_start_time_next = raw_change_time_next;
        end
      end
      // raw release clears the armed, pending, qualified and expired flags
      if (!btn) begin
        armed_flag_next      = 1'b0;
        on_pending_flag_next = 1'b0;
        qualified_flag_next  = 1'b0;
        expired_flag_next    = 1'b0;
      end
      if (btn && qualified_flag_next &&
          ((now - armed_since_time) >= cfg.arm_timeout_ms)) begin
        expired_flag_next    = 1'b1;
        armed_flag_next      = 1'b0;
        on_pending_flag_next = 1'b0;
      end
      if (!expired_flag_next) begin
        if (!smp.ignition_on) begin
          if (!off_known_flag) begin
            off_since_time_next = now;
            off_known_flag_next = 1'b1;
          end
          on_pending_flag_next = 1'b0;
          if (debounced_button_next && btn &&
              ((now - off_since_time_next) >= cfg.off_settle_ms) &&
              ((now - press_start_time_next) >= cfg.press_hold_ms)) begin
            if (!qualified_flag_next) begin
              qualified_flag_next   = 1'b1;
              armed_since_time_next = now;
            end
            armed_flag_next = 1'b1;
          end
        end else begin
          // ignition turned on while armed starts the hold timer
          if (off_known_flag && armed_flag_next && debounced_button_next && btn) begin
            on_since_time_next   = now;
            on_pending_flag_next = 1'b1;
          end
          off_known_flag_next = 1'b0;
          armed_flag_next     = 1'b0;
          if (on_pending_flag_next && debounced_button_next && btn &&
              ((now - on_since_time_next) >= cfg.on_hold_ms)) begin
            on_pending_flag_next = 1'b0;
            fire                 = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_button       <= 1'b0;
      raw_change_time  <= '0;
      debounced_button <= 1'b0;
      press_start_time <= '0;
      armed_flag       <= 1'b0;
      on_pending_flag  <= 1'b0;
      qualified_flag   <= 1'b0;
      expired_flag     <= 1'b0;
      armed_since_time <= '0;
      off_known_flag   <= 1'b0;
      off_since_time   <= '0;
      on_since_time    <= '0;
    end else if (step) begin
      raw_button       <= raw_button_next;
      raw_change_time  <= raw_change_time_next;
      debounced_button <= debounced_button_next;
      press_start_time <= press_start_time_next;
      armed_flag       <= armed_flag_next;
      on_pending_flag  <= on_pending_flag_next;
      qualified_flag   <= qualified_flag_next;
      expired_flag     <= expired_flag_next;
      armed_since_time <= armed_since_time_next;
      off_known_flag   <= off_known_flag_next;
      off_since_time   <= off_since_time_next;
      on_since_time    <= on_since_time_next;
    end
  end

endmodule

// ===== rtl/ignition_button_gesture_gate_top.sv =====
// ----------------------------------------------------------------------------
// ignition_button_gesture_gate_top
// Ignition/button gesture gate: debounces the enter button and raises a
// recovery request after the off-press-on-hold gesture.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_stall   | action, now_ms, ignition_on, enter_button
//  out     | out_valid / out_stall | recovery_request
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  one sample per cycle sustained while out_stall is low; a sample passes the
//  input register, then the gesture state update into the result register.
//  the gesture state advances when a sample moves from the input register
//  into the result register.
//  out_stall holds the result register; an empty input register still takes
//  one more transaction, a full one raises in_stall in the same cycle.
//  rst is synchronous; thresholds return to their defaults, state to zero.
// ----------------------------------------------------------------------------
module ignition_button_gesture_gate_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  ibgg_pkg::time_ms_t now_ms,
  input  logic               ignition_on,
  input  logic               enter_button,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               recovery_request,
  input  logic               cfg_write,
  input  ibgg_pkg::cfg_idx_t cfg_index,
  input  ibgg_pkg::time_ms_t cfg_data
);

  ibgg_pkg::cfg_t    cfg;
  ibgg_pkg::sample_t smp;
  logic              smp_valid;
  logic              out_free;
  logic              advance;
  logic              fire;

  assign out_free = !out_valid || !out_stall;
  assign advance  = smp_valid && out_free;
  assign in_stall = smp_valid && !out_free;

  ibgg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ibgg_gesture u_gesture (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .smp  (smp),
    .cfg  (cfg),
    .fire (fire)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!in_stall) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp.action       <= action;
      smp.now_ms       <= now_ms;
      smp.ignition_on  <= ignition_on;
      smp.enter_button <= enter_button;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      recovery_request <= fire;
    end
  end

endmodule
